### hw/rtl/uart_rx_fifo_register_block_defines.svh
// Assertion macros used by the UART register block checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef UART_RX_FIFO_REGISTER_BLOCK_DEFINES_SVH
`define UART_RX_FIFO_REGISTER_BLOCK_DEFINES_SVH

// Check on every clock edge outside reset.
`define URX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define URX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### hw/rtl/uartrx_pkg.sv
// Shared types and constants for the UART receive FIFO register block.
// No dependencies.
`timescale 1ns / 1ps

package uartrx_pkg;

  localparam int unsigned FifoDepth = 16;
  localparam int unsigned PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OpRxByte   = 2'd0,
    OpBusRead  = 2'd1,
    OpBusWrite = 2'd2
  } op_e;

  typedef enum logic {
    CfgControl     = 1'b0,
    CfgLineControl = 1'b1
  } cfg_idx_e;

  // Register offsets
  localparam logic [11:0] AddrDr   = 12'h000;
  localparam logic [11:0] AddrRsr  = 12'h004;
  localparam logic [11:0] AddrFr   = 12'h018;
  localparam logic [11:0] AddrLcr  = 12'h02C;
  localparam logic [11:0] AddrCr   = 12'h030;
  localparam logic [11:0] AddrImsc = 12'h038;
  localparam logic [11:0] AddrRis  = 12'h03C;
  localparam logic [11:0] AddrMis  = 12'h040;
  localparam logic [11:0] AddrIcr  = 12'h044;

  // Bit positions
  localparam int unsigned CrUartEn  = 0;
  localparam int unsigned CrTxEn    = 8;
  localparam int unsigned CrRxEn    = 9;
  localparam int unsigned LcrFifoEn = 4;
  localparam int unsigned IntRxBit  = 4;
  localparam int unsigned IntTxBit  = 5;

  localparam logic [15:0] ControlReset = 16'h0300;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } rxq_ctrl_t;

  typedef struct packed {
    cnt_t count;
    cnt_t count_next;
  } rxq_stat_t;

endpackage

### hw/rtl/uartrx_if.sv
// Valid/ready channel interfaces for the UART register block.
// No dependencies.
`timescale 1ns / 1ps

interface uartrx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] address;
  logic [15:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, operation, address, write_data, rx_byte, input ready);
  modport sink   (input valid, operation, address, write_data, rx_byte, output ready);
endinterface

interface uartrx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        irq;

  modport source (output valid, read_data, tx_valid, tx_byte, irq, input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, irq, output ready);
endinterface

### hw/rtl/uartrx_rxq.sv
// Receive FIFO: byte RAM with registered read port plus head and count.
// Depends on uartrx_pkg.
`timescale 1ns / 1ps

module uartrx_rxq import uartrx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rxq_ctrl_t  ctrl_i,
  output rxq_stat_t  stat_o,
  output logic [7:0] rdata_o
);

  localparam int unsigned SumW = CntW + 1;

  logic [7:0]      mem_q [FifoDepth];
  logic [7:0]      rdata_q;
  ptr_t            head_q, head_d;
  cnt_t            count_q, count_d;
  logic [SumW-1:0] tail_sum;
  ptr_t            tail;

  // Head plus count stays below twice the depth whenever a push is allowed.
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(FifoDepth)) begin
      tail_sum = tail_sum - SumW'(FifoDepth);
    end
    tail = tail_sum[PtrW-1:0];
  end

  always_comb begin
    head_d = head_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == PtrW'(FifoDepth - 1)) ? '0 : PtrW'(head_q + 1'b1);
    end
    count_d = CntW'(count_q + CntW'(ctrl_i.push) - CntW'(ctrl_i.pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail] <= ctrl_i.wdata;
    end
  end

  // Hold read data until the next pop.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign stat_o.count      = count_q;
  assign stat_o.count_next = count_d;
  assign rdata_o           = rdata_q;

endmodule

### hw/rtl/uart_rx_fifo_register_block.sv
// Channel   | Dir | Payload
// item_i    | in  | operation, address, write_data, rx_byte
// result_o  | out | read_data, tx_valid, tx_byte, irq
// cfg_*_i   | in  | write enable, register index, 16-bit data
//
// One item per cycle unless stalled; each result appears in the output register the
// cycle after acceptance, with popped bytes taken from the FIFO RAM's read register.
// All state updates for an item complete in its acceptance cycle.
// Reset is asynchronous and clears control state; the RAM is not cleared.
// item_i.ready drops only while an untaken result sits in the output register.
// Depends on uartrx_pkg, uartrx_if and uartrx_rxq.
`timescale 1ns / 1ps

module uart_rx_fifo_register_block import uartrx_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  uartrx_in_if.sink     item_i,
  uartrx_out_if.source  result_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic [15:0] control_q;
  logic [7:0]  lcr_q;
  logic [10:0] mask_q, mask_d;
  logic        tx_int_q, tx_int_d;

  logic        out_valid_q;
  logic [15:0] rdata_q;
  logic        pop_q;
  logic        txv_q;
  logic [7:0]  txb_q;
  logic        irq_q;

  logic        accept;
  logic        push, pop, tx_send;
  logic [15:0] rdata_d;
  logic        irq_d;
  cnt_t        cur_depth;
  logic        rx_empty, rx_full;
  logic [10:0] raw;
  rxq_ctrl_t   rxq_ctrl;
  rxq_stat_t   rxq_stat;
  logic [7:0]  rxq_rdata;

  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  assign cur_depth = lcr_q[LcrFifoEn] ? CntW'(FifoDepth) : CntW'(1);
  assign rx_empty  = (rxq_stat.count == '0);
  assign rx_full   = (rxq_stat.count >= cur_depth);

  always_comb begin
    raw           = '0;
    raw[IntRxBit] = !rx_empty;
    raw[IntTxBit] = tx_int_q;
  end

  always_comb begin
    push     = 1'b0;
    pop      = 1'b0;
    tx_send  = 1'b0;
    mask_d   = mask_q;
    tx_int_d = tx_int_q;
    rdata_d  = '0;
    if (accept) begin
      case (op_e'(item_i.operation))
        OpRxByte: begin
          push = control_q[CrUartEn] && control_q[CrRxEn] && !rx_full &&
                 (rxq_stat.count < CntW'(FifoDepth));
        end
        OpBusRead: begin
          case (item_i.address)
            AddrDr:   pop = !rx_empty;
            AddrFr:   begin
              rdata_d[7] = 1'b1;
              rdata_d[6] = rx_full;
              rdata_d[4] = rx_empty;
            end
            AddrLcr:  rdata_d = {8'h00, lcr_q};
            AddrCr:   rdata_d = control_q;
            AddrImsc: rdata_d = {5'b0, mask_q};
            AddrRis:  rdata_d = {5'b0, raw};
            AddrMis:  rdata_d = {5'b0, raw & mask_q};
            default:  rdata_d = '0;
          endcase
        end
        OpBusWrite: begin
          case (item_i.address)
            AddrDr: begin
              if (control_q[CrTxEn]) begin
                tx_send  = 1'b1;
                tx_int_d = 1'b1;
              end
            end
            AddrImsc: mask_d   = item_i.write_data[10:0];
            AddrIcr:  tx_int_d = tx_int_q & ~item_i.write_data[IntTxBit];
            default:  ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Interrupt line reflects state after this item.
  assign irq_d = (tx_int_d && mask_d[IntTxBit]) ||
                 ((rxq_stat.count_next != '0) && mask_d[IntRxBit]);

  assign rxq_ctrl.push  = push;
  assign rxq_ctrl.pop   = pop;
  assign rxq_ctrl.wdata = item_i.rx_byte;

  uartrx_rxq u_rxq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rxq_ctrl),
    .stat_o  (rxq_stat),
    .rdata_o (rxq_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= ControlReset;
      lcr_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgControl:     control_q <= cfg_wdata_i;
        CfgLineControl: lcr_q     <= cfg_wdata_i[7:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      tx_int_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      tx_int_q <= tx_int_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result while the sink stalls.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= rdata_d;
      pop_q   <= pop;
      txv_q   <= tx_send;
      txb_q   <= tx_send ? item_i.write_data[7:0] : 8'h00;
      irq_q   <= irq_d;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.read_data = pop_q ? {8'h00, rxq_rdata} : rdata_q;
  assign result_o.tx_valid  = txv_q;
  assign result_o.tx_byte   = txb_q;
  assign result_o.irq       = irq_q;

endmodule

### hw/rtl/uartrx_checker.sv
// Port-level checks for the UART register block, bound to the top level.
// Depends on uart_rx_fifo_register_block_defines.svh.
`timescale 1ns / 1ps
`include "uart_rx_fifo_register_block_defines.svh"

module uartrx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       tx_valid_i,
  input logic [7:0] tx_byte_i
);

  `URX_ASSERT(a_result_follows, in_valid_i && in_ready_i |=> out_valid_i, "no result after accepted transaction")
  `URX_ASSERT(a_ready_needs_room, in_ready_i |-> (!out_valid_i || out_ready_i), "input ready while output blocked")
  `URX_ASSERT(a_tx_byte_quiet, out_valid_i && !tx_valid_i |-> tx_byte_i == 8'h00, "tx byte set without tx valid")
  `URX_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `URX_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind uart_rx_fifo_register_block uartrx_checker u_uartrx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .tx_valid_i  (result_o.tx_valid),
  .tx_byte_i   (result_o.tx_byte)
);
